// ===== sv/assert_macros.svh =====
// Shared assertion macros for the hash engine checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that a property holds at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert that a condition at one edge implies a property at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== sv/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg
// Types, constants and round functions shared by the SHA-256 hash engine.
// ----------------------------------------------------------------------------
package sha_pkg;

	// Word as it passes from the front end to the compression core.
	typedef struct packed {
		logic [31:0] word;
		logic        final_word;
	} blk_word_t;

	// Front-end queue depth.
	localparam int QDepth = 4;
	localparam int QAw    = $clog2(QDepth);

	localparam logic [31:0] PadWord = 32'h8000_0000;

	// Round constants.
	function automatic logic [31:0] round_k(input logic [5:0] r);
		logic [31:0] k;
		case (r)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	// Initial hash words.
	function automatic logic [31:0] init_h(input logic [2:0] i);
		logic [31:0] h;
		case (i)
			3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
			3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
			3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
			3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
		endcase
		return h;
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ===== sv/sha_front.sv =====
// ----------------------------------------------------------------------------
// sha_front
// Accepts message words, applies the padding and length trailer, and queues
// whole block words for the compression core.
// ----------------------------------------------------------------------------
module sha_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [31:0]        in_data,
	input  logic [2:0]         in_vb,
	input  logic               in_last,
	output logic               q_valid,
	input  logic               q_ready,
	output sha_pkg::blk_word_t q_data
);

	localparam logic [1:0] StIn   = 2'd0;
	localparam logic [1:0] StPad  = 2'd1;
	localparam logic [1:0] StLenH = 2'd2;
	localparam logic [1:0] StLenL = 2'd3;

	logic [1:0]  state_q;
	logic [3:0]  fill_q;
	logic [60:0] len_q;
	logic        extra_q;

	sha_pkg::blk_word_t mem_q [sha_pkg::QDepth];
	logic [sha_pkg::QAw-1:0] wp_q, rp_q;
	logic [sha_pkg::QAw:0]   cnt_q;

	logic               push, full;
	sha_pkg::blk_word_t push_d;
	logic [2:0]         vb;
	logic [31:0]        last_w, mask;
	logic [63:0]        bits;

	assign full = (cnt_q == (sha_pkg::QAw+1)'(sha_pkg::QDepth));
	assign vb   = (in_vb > 3'd4) ? 3'd4 : in_vb;
	assign bits = {len_q, 3'b000};

	// Masked final word, with the pad bit after its valid bytes when fewer than four are valid.
	always_comb begin
		case (vb)
			3'd0: mask = 32'h0000_0000;
			3'd1: mask = 32'hff00_0000;
			3'd2: mask = 32'hffff_0000;
			3'd3: mask = 32'hffff_ff00;
			default: mask = 32'hffff_ffff;
		endcase
		last_w = (in_data & mask) | ((vb == 3'd4) ? 32'd0 : (sha_pkg::PadWord >> {vb, 3'b000}));
	end

	// Word selection for the queue.
	always_comb begin
		push = 1'b0;
		push_d.word = 32'd0;
		push_d.final_word = 1'b0;
		in_ready = 1'b0;
		case (state_q)
			StIn: begin
				in_ready = !full;
				push = in_valid && !full;
				push_d.word = in_last ? last_w : in_data;
			end
			StPad: begin
				push = !full;
				push_d.word = extra_q ? sha_pkg::PadWord : 32'd0;
			end
			StLenH: begin
				push = !full;
				push_d.word = bits[63:32];
			end
			default: begin
				push = !full;
				push_d.word = bits[31:0];
				push_d.final_word = 1'b1;
			end
		endcase
	end

	// Sequencer for padding and length; the fill count wraps to zero after
	// the low length word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIn;
			fill_q  <= 4'd0;
			len_q   <= 61'd0;
			extra_q <= 1'b0;
		end else if (push) begin
			fill_q <= fill_q + 4'd1;
			case (state_q)
				StIn: begin
					if (in_last) begin
						len_q   <= len_q + 61'(vb);
						extra_q <= (vb == 3'd4);
						state_q <= ((vb != 3'd4) && (fill_q == 4'd13)) ? StLenH : StPad;
					end else begin
						len_q <= len_q + 61'd4;
					end
				end
				StPad: begin
					extra_q <= 1'b0;
					if (fill_q == 4'd13) state_q <= StLenH;
				end
				StLenH: state_q <= StLenL;
				default: begin
					state_q <= StIn;
					len_q   <= 61'd0;
				end
			endcase
		end
	end

	// Word queue toward the core.
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (q_valid && q_ready) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (sha_pkg::QAw+1)'(push) - (sha_pkg::QAw+1)'(q_valid && q_ready);
		end
	end

	assign q_valid = (cnt_q != '0);
	assign q_data  = mem_q[rp_q];

endmodule

// ===== sv/sha_core.sv =====
// ----------------------------------------------------------------------------
// sha_core
// Collects 16 block words, runs 64 rounds one per cycle, and emits the
// digest after a final block.
// ----------------------------------------------------------------------------
module sha_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_ready,
	input  sha_pkg::blk_word_t q_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        out_word,
	output logic [2:0]         out_idx,
	output logic               out_end
);

	localparam logic [1:0] StLoad  = 2'd0;
	localparam logic [1:0] StRound = 2'd1;
	localparam logic [1:0] StAdd   = 2'd2;
	localparam logic [1:0] StOut   = 2'd3;

	logic [1:0]  state_q;
	logic [5:0]  cnt_q;
	logic        fin_q;
	logic [31:0] w_q [16];
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] s0, s1, wn, wcur, e1, ch, a0, mj, t1, t2;

	assign q_ready = (state_q == StLoad);
	assign wcur    = w_q[0];

	// Schedule word sixteen ahead and round datapath.
	always_comb begin
		s0 = sha_pkg::rotr(w_q[1], 7) ^ sha_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = sha_pkg::rotr(w_q[14], 17) ^ sha_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		wn = w_q[0] + s0 + w_q[9] + s1;
		e1 = sha_pkg::rotr(v_q[4], 6) ^ sha_pkg::rotr(v_q[4], 11) ^ sha_pkg::rotr(v_q[4], 25);
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1 = v_q[7] + e1 + ch + sha_pkg::round_k(cnt_q) + wcur;
		a0 = sha_pkg::rotr(v_q[0], 2) ^ sha_pkg::rotr(v_q[0], 13) ^ sha_pkg::rotr(v_q[0], 22);
		mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2 = a0 + mj;
	end

	// Block schedule window, shifted once per word loaded or round run.
	always_ff @(posedge clk) begin
		if ((state_q == StLoad && q_valid) || state_q == StRound) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= (state_q == StLoad) ? q_data.word : wn;
		end
		if (state_q == StLoad) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end else if (state_q == StRound) begin
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	// Sequencer and chaining value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StLoad;
			cnt_q   <= 6'd0;
			fin_q   <= 1'b0;
			for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::init_h(3'(i));
		end else begin
			case (state_q)
				StLoad: if (q_valid) begin
					if (cnt_q == 6'd15) begin
						cnt_q   <= 6'd0;
						fin_q   <= q_data.final_word;
						state_q <= StRound;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				StRound: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) state_q <= StAdd;
				end
				StAdd: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					cnt_q   <= 6'd0;
					state_q <= fin_q ? StOut : StLoad;
				end
				default: if (out_ready) begin
					if (cnt_q == 6'd7) begin
						for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::init_h(3'(i));
						cnt_q   <= 6'd0;
						state_q <= StLoad;
					end else begin
						for (int i = 0; i < 7; i++) h_q[i] <= h_q[i+1];
						h_q[7] <= sha_pkg::init_h(3'(cnt_q + 6'd1));
						cnt_q  <= cnt_q + 6'd1;
					end
				end
			endcase
		end
	end

	assign out_valid = (state_q == StOut);
	assign out_word  = h_q[0];
	assign out_idx   = cnt_q[2:0];
	assign out_end   = (cnt_q[2:0] == 3'd7);

endmodule

// ===== sv/sha256_hash_engine.sv =====
// ----------------------------------------------------------------------------
// sha256_hash_engine
// SHA-256 over a stream of big-endian message words, eight digest words out.
// ----------------------------------------------------------------------------
// A user feeds message words on s_axis; the word with tlast set ends the message
// and may hold 0 to 4 valid bytes. Each 16-word block is loaded from the
// internal four-entry queue and then run through the one-round-per-cycle
// compression core, which takes no new words until the block is done. Padding
// completes the last block and adds one more when the pad and length do not fit,
// after which the eight digest words appear on m_axis, index 0 first, tlast on the eighth.
module sha256_hash_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // data_word[31:0], valid_bytes[34:32], zero fill
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // digest_word[31:0], word_index[34:32], zero fill
	output logic        m_axis_tlast
);

	logic               q_valid, q_ready;
	sha_pkg::blk_word_t q_data;
	logic [31:0]        dword;
	logic [2:0]         didx;

	// Front end: padding and queue.
	sha_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_data(s_axis_tdata[31:0]), .in_vb(s_axis_tdata[34:32]),
		.in_last(s_axis_tlast),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
	);

	// Back end: compression and digest output.
	sha_core u_core (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_word(dword), .out_idx(didx), .out_end(m_axis_tlast)
	);

	assign m_axis_tdata = {5'd0, didx, dword};

endmodule

// ===== sv/sha_checker.sv =====
// ----------------------------------------------------------------------------
// sha_checker
// Port-level checks on the digest output of the hash engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sha_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	// The last flag marks word index seven exactly.
	`ASSERT_CLK(a_last_idx, clk, arst_n, m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[34:32] == 3'd7)), "tlast does not match index seven")

	// After a non-final digest word is taken, the next index follows.
	`ASSERT_NEXT(a_idx_step, clk, arst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1, "digest index did not advance")

	// A stalled digest word holds.
	`ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "digest word changed under stall")

endmodule

bind sha256_hash_engine sha_checker u_sha_checker (
	.clk(clk), .arst_n(arst_n),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);

// ===== dv/sha256_hash_engine_tb.sv =====
// ----------------------------------------------------------------------------
// sha256_hash_engine_tb
// Self-checking bench for the SHA-256 engine: a scoreboard predicts the digest
// of every message fed in and checks each digest word that comes out.
// ----------------------------------------------------------------------------

// Scoreboard: keeps its own hash state and a queue of expected digest words.
class digest_scoreboard;
	bit [31:0] chain[8];
	bit [31:0] blk[16];
	int unsigned fill;
	bit [60:0] byte_count;
	bit [35:0] pending[$];	// {tlast, index, word}
	int errors;
	int words_checked;
	int messages;

	function new();
		restart();
		errors = 0;
		words_checked = 0;
		messages = 0;
	endfunction

	function void restart();
		chain[0] = 32'h6a09e667; chain[1] = 32'hbb67ae85;
		chain[2] = 32'h3c6ef372; chain[3] = 32'ha54ff53a;
		chain[4] = 32'h510e527f; chain[5] = 32'h9b05688c;
		chain[6] = 32'h1f83d9ab; chain[7] = 32'h5be0cd19;
		fill = 0;
		byte_count = '0;
	endfunction

	function bit [31:0] ror(bit [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// Round constant table.
	function bit [31:0] kconst(int r);
		bit [31:0] kt[64];
		kt = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
			32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
			32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
			32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
			32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
			32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
			32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
			32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
			32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
			32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		return kt[r];
	endfunction

	// Run the 64 rounds over the held block into the chaining value.
	function void compress();
		bit [31:0] w[64];
		bit [31:0] v[8];
		bit [31:0] t1, t2, s0, s1;
		for (int r = 0; r < 16; r++) w[r] = blk[r];
		for (int r = 16; r < 64; r++) begin
			s0 = ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3);
			s1 = ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10);
			w[r] = w[r-16] + s0 + w[r-7] + s1;
		end
		v = chain;
		for (int r = 0; r < 64; r++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + kconst(r) + w[r];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int r = 0; r < 8; r++) chain[r] += v[r];
	endfunction

	function void absorb(bit [31:0] wd);
		blk[fill] = wd;
		fill++;
		if (fill == 16) begin
			compress();
			fill = 0;
		end
	endfunction

	// Note one accepted input word; a last word queues the eight digest words.
	function void note_word(bit [31:0] data, bit [2:0] nbytes, bit last);
		bit [31:0] wd;
		bit [63:0] bits;
		int nb;
		if (!last) begin
			absorb(data);
			byte_count += 61'd4;
			return;
		end
		nb = (nbytes > 4) ? 4 : nbytes;
		byte_count += 61'(nb);
		// Keep the valid leading bytes and place the pad byte right after them.
		if (nb == 0) wd = 32'h8000_0000;
		else if (nb == 4) wd = data;
		else wd = (data & (32'hffff_ffff << (32 - 8*nb))) | (32'h80 << (24 - 8*nb));
		absorb(wd);
		if (nb == 4) absorb(32'h8000_0000);
		if (fill > 14) while (fill != 0) absorb(32'd0);
		while (fill < 14) absorb(32'd0);
		bits = {byte_count, 3'b000};
		absorb(bits[63:32]);
		absorb(bits[31:0]);
		for (int i = 0; i < 8; i++)
			pending.push_back({(i == 7), 3'(i), chain[i]});
		messages++;
		restart();
	endfunction

	task report(string what, bit [35:0] got, bit [35:0] want);
		errors++;
		$display("mismatch in %s: got tlast=%0d idx=%0d %08h, want tlast=%0d idx=%0d %08h",
			what, got[35], got[34:32], got[31:0], want[35], want[34:32], want[31:0]);
	endtask

	// Check one accepted digest word against the oldest expectation.
	task check_word(bit [31:0] wd, bit [2:0] idx, bit last);
		bit [35:0] want;
		if (pending.size() == 0) begin
			report("unexpected digest word", {last, idx, wd}, '0);
			return;
		end
		want = pending.pop_front();
		words_checked++;
		if (want[31:0] != wd) report("digest_word", {last, idx, wd}, want);
		if (want[34:32] != idx) report("word_index", {last, idx, wd}, want);
		if (want[35] != last) report("digest_end", {last, idx, wd}, want);
	endtask
endclass

module sha256_hash_engine_tb;
	localparam int StallLimit = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tlast;

	digest_scoreboard sb = new();
	int  src_idle_pct = 14;
	int  snk_idle_pct = 76;
	bit  hold_sink = 1'b0;
	int  quiet_cycles = 0;
	int  words_sent = 0;

	sha256_hash_engine dut (.*);

	always #5 clk = ~clk;

	// Sink: random backpressure, or a long hold when asked.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_word(m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tlast);
			m_axis_tready <= !hold_sink && ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// Watchdog on cycles with no transaction on either side.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > StallLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Offer one word and hold it until accepted, with random gaps before it.
	// Valid stays high after acceptance unless a gap follows or the caller
	// drops it, so words can follow back to back.
	task automatic send_word(bit [31:0] data, bit [2:0] nbytes, bit last);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {5'b0, nbytes, data};
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_word(data, nbytes, last);
		words_sent++;
	endtask

	// Send a message of n full words then a last word with nb valid bytes.
	task automatic send_message(int n, bit [2:0] nb);
		for (int i = 0; i < n; i++)
			send_word($urandom, 3'($urandom_range(7)), 1'b0);
		send_word($urandom, nb, 1'b1);
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty message, the known "abc" vector, data extremes, every
		// byte count, oversized counts and lengths near the padding boundaries.
		send_word(32'hffff_ffff, 3'd0, 1'b1);
		send_word(32'h6162_6300, 3'd3, 1'b1);
		send_word(32'h0000_0000, 3'd4, 1'b1);
		send_word(32'hffff_ffff, 3'd4, 1'b1);
		send_word(32'hffff_ffff, 3'd7, 1'b1);
		send_word(32'hffff_ffff, 3'd5, 1'b1);
		send_word(32'h1234_5678, 3'd1, 1'b1);
		send_word(32'h1234_5678, 3'd2, 1'b0);
		send_word(32'h9abc_def0, 3'd2, 1'b1);
		send_message(13, 3'd4);
		send_message(13, 3'd3);
		send_message(14, 3'd0);
		send_message(15, 3'd2);
		s_axis_tvalid <= 1'b0;
		drain();

		// Pause until all digests are out, then hold the sink while feeding.
		hold_sink = 1'b1;
		fork
			begin repeat (600) @(posedge clk); hold_sink = 1'b0; end
			begin
				repeat (4) send_message($urandom_range(20), 3'($urandom_range(4)));
				s_axis_tvalid <= 1'b0;
			end
		join
		drain();

		// Random messages over three idle profiles, mostly short.
		for (int phase = 0; phase < 3; phase++) begin
			src_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 76 : 0;
			snk_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 14 : 0;
			repeat (8)
				send_message(($urandom_range(9) == 0) ? $urandom_range(40, 33)
					: $urandom_range(16), 3'($urandom_range(7)));
		end
		s_axis_tvalid <= 1'b0;
		drain();
		repeat (400) @(posedge clk);

		$display("Fed %0d words in %0d messages; %0d digest words checked.",
			words_sent, sb.messages, sb.words_checked);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// ===== sha256_hash_engine.f =====
+incdir+sv
sv/sha_pkg.sv
sv/sha_front.sv
sv/sha_core.sv
sv/sha256_hash_engine.sv
sv/sha_checker.sv
dv/sha256_hash_engine_tb.sv
